@@ design/pdle_pkg.sv @@
// package for the packet delay/loss emulator: widths, command and csr codes, payload types
// no dependencies
`default_nettype none
package pdle_pkg;
   localparam int unsigned SLOTS_DEFAULT       = 256;
   localparam int unsigned READY_SLOTS_DEFAULT = 64;
   localparam int unsigned TIME_W  = 48;
   localparam int unsigned ADDR_W  = 32;
   localparam int unsigned HL_W    = 28;
   localparam int unsigned LAT_W   = 20;
   localparam int unsigned THR_W   = 17;

   localparam logic [1:0] CMD_SEND    = 2'd0;
   localparam logic [1:0] CMD_UPDATE  = 2'd1;
   localparam logic [1:0] CMD_RECEIVE = 2'd2;

   localparam logic [1:0] CSR_LATENCY = 2'd0;
   localparam logic [1:0] CSR_JITTER  = 2'd1;
   localparam logic [1:0] CSR_LOSS    = 2'd2;
   localparam logic [1:0] CSR_DUP     = 2'd3;

   // one second in microseconds and the draw full scale
   localparam logic [19:0] ONE_SEC_US = 20'd1000000;
   localparam logic [16:0] DRAW_FULL  = 17'd65535;

   typedef struct packed {
      logic [1:0]  command;
      logic [47:0] time_now;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] packet_handle;
      logic [11:0] packet_len;
      logic [6:0]  max_count;
      logic [15:0] rand_loss;
      logic [15:0] rand_jitter;
      logic [15:0] rand_dup;
      logic [15:0] rand_dup_delay;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [31:0] out_src_addr;
      logic [15:0] out_handle;
      logic [11:0] out_len;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  index;
      logic [31:0] data;
   } csr_type;
endpackage
`default_nettype wire

@@ design/pdle_if.sv @@
// valid/ready channel interfaces, each carrying one payload type
// depends on pdle_pkg for the payload types
`default_nettype none
interface pdle_req_if;
   logic valid;
   logic ready;
   pdle_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface pdle_rsp_if;
   logic valid;
   logic ready;
   pdle_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface pdle_csr_if;
   logic valid;
   logic ready;
   pdle_pkg::csr_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ design/pdle_ram.sv @@
// generic single write port, single registered read port ram
// no dependencies
`default_nettype none
module pdle_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

@@ design/pdle_ctrl.sv @@
// controller: sequences send, update scan and receive scan
// depends on pdle_pkg
`default_nettype none
module pdle_ctrl #(
   parameter int unsigned SLOTS       = pdle_pkg::SLOTS_DEFAULT,
   parameter int unsigned READY_SLOTS = pdle_pkg::READY_SLOTS_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_command,
   input  wire logic       rsp_ready,
   output logic            rsp_valid,
   output logic [6:0]      st_cmd,
   input  wire logic [6:0] dp_status
);
   localparam int unsigned SW = $clog2(SLOTS);
   localparam int unsigned RW = (READY_SLOTS > 1) ? $clog2(READY_SLOTS) : 1;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SEND  = 3'd1;
   localparam logic [2:0] S_SEND2 = 3'd2;
   localparam logic [2:0] S_UPD   = 3'd3;
   localparam logic [2:0] S_RCV   = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   // dp_status: {scan_done, is_dup, is_drop, rcv_done, rcv_hit, rcv_last, unused}
   logic [2:0] state_ff, state_in;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

   // st_cmd: {start_send, start_upd, start_rcv, step_send, step_upd, step_rcv, out_taken}
   always_comb begin
      state_in = state_ff;
      st_cmd   = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_command)
                  pdle_pkg::CMD_SEND:    begin st_cmd[6] = 1'b1; state_in = S_SEND; end
                  pdle_pkg::CMD_UPDATE:  begin st_cmd[5] = 1'b1; state_in = S_UPD; end
                  pdle_pkg::CMD_RECEIVE: begin st_cmd[4] = 1'b1; state_in = S_RCV; end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_SEND: begin
            st_cmd[3] = 1'b1;
            state_in = (dp_status[5] && !dp_status[4]) ? S_SEND2 : S_IDLE;
         end
         S_SEND2: begin
            state_in = S_IDLE;
         end
         S_UPD: begin
            st_cmd[2] = 1'b1;
            if (dp_status[6]) state_in = S_IDLE;
         end
         S_RCV: begin
            st_cmd[1] = 1'b1;
            if (dp_status[2] || dp_status[3]) state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_ready) begin
               st_cmd[0] = 1'b1;
               state_in = dp_status[1] ? S_IDLE : S_RCV;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end
   logic unused_ok;
   assign unused_ok = dp_status[0] ^ SW[0] ^ RW[0];
endmodule
`default_nettype wire

@@ design/pdle_dp.sv @@
// datapath: slot ring, ready list, due time arithmetic and receive result register
// depends on pdle_pkg and pdle_ram
`default_nettype none
module pdle_dp #(
   parameter int unsigned SLOTS       = pdle_pkg::SLOTS_DEFAULT,
   parameter int unsigned READY_SLOTS = pdle_pkg::READY_SLOTS_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire pdle_pkg::req_type req,
   input  wire logic              csr_we,
   input  wire pdle_pkg::csr_type csr,
   input  wire logic [6:0]        st_cmd,
   output logic [6:0]             dp_status,
   output pdle_pkg::rsp_type      rsp
);
   localparam int unsigned SW  = $clog2(SLOTS);
   localparam int unsigned RW  = (READY_SLOTS > 1) ? $clog2(READY_SLOTS) : 1;
   localparam int unsigned RCW = $clog2(READY_SLOTS + 1);
   localparam logic [SW-1:0] SLOT_LAST  = SW'(SLOTS - 1);
   localparam logic [RCW-1:0] READY_MAX = RCW'(READY_SLOTS);
   localparam int unsigned DW = 2 * pdle_pkg::ADDR_W + pdle_pkg::HL_W + pdle_pkg::TIME_W;

   logic [19:0] latency_ff, jitter_ff;
   logic [16:0] loss_ff, dup_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         latency_ff <= '0; jitter_ff <= '0; loss_ff <= '0; dup_ff <= '0;
      end else if (csr_we) begin
         case (csr.index)
            pdle_pkg::CSR_LATENCY: latency_ff <= csr.data[19:0];
            pdle_pkg::CSR_JITTER:  jitter_ff  <= csr.data[19:0];
            pdle_pkg::CSR_LOSS:    loss_ff    <= csr.data[16:0];
            pdle_pkg::CSR_DUP:     dup_ff     <= csr.data[16:0];
            default: ;
         endcase
      end
   end

   pdle_pkg::req_type req_ff;
   logic [47:0] time_ff;
   logic [SW-1:0] wp_ff;
   logic [SLOTS-1:0] sv_ff;
   logic [READY_SLOTS-1:0] rv_ff;
   logic [RCW-1:0] rcnt_ff;
   logic [SW:0] scan_ff;
   logic [RCW-1:0] rscan_ff;
   logic [6:0] nout_ff;
   logic [6:0] maxc_ff;
   logic scan_pend_ff, rpend_ff;
   logic signed [50:0] base_ff;
   logic [19:0] extra_ff;

   // floor(x / 65535) by folding the upper half back onto the lower half
   function automatic logic [20:0] div_draw(input logic [36:0] x);
      logic [21:0] y;
      logic [16:0] z;
      y = 22'(x[36:16]) + 22'(x[15:0]);
      z = 17'(y[21:16]) + 17'(y[15:0]);
      return 21'(x[36:16]) + 21'(y[21:16])
             + ((z >= pdle_pkg::DRAW_FULL) ? 21'd1 : 21'd0);
   endfunction

   // due time: computed at accept, written in the send step
   logic [36:0] jprod;
   logic [35:0] dprod;
   logic [20:0] span;
   logic [19:0] extra;
   assign jprod = 37'(req.rand_jitter) * 37'({jitter_ff, 1'b0});
   assign dprod = 36'(req.rand_dup_delay) * 36'(pdle_pkg::ONE_SEC_US);
   assign span  = div_draw(jprod);
   assign extra = 20'(div_draw(37'(dprod)));

   function automatic logic [47:0] clamp(input logic signed [50:0] t);
      if (t < 0) return '0;
      if (t > 51'sh0FFFFFFFFFFFF) return 48'hFFFFFFFFFFFF;
      return t[47:0];
   endfunction

   logic drop, dup;
   assign drop = {1'b0, req_ff.rand_loss} < loss_ff;
   assign dup  = {1'b0, req_ff.rand_dup} < dup_ff;

   // slot ring ram
   logic s_we; logic [SW-1:0] s_wa, s_ra; logic [DW-1:0] s_wd, s_rd;
   pdle_ram #(.WIDTH(DW), .DEPTH(SLOTS)) u_slot (
      .clock(clock), .wr_en(s_we), .wr_addr(s_wa), .wr_data(s_wd),
      .rd_addr(s_ra), .rd_data(s_rd));
   // ready list ram
   localparam int unsigned RDW = 2 * pdle_pkg::ADDR_W + pdle_pkg::HL_W;
   logic r_we; logic [RW-1:0] r_wa, r_ra; logic [RDW-1:0] r_wd, r_rd;
   pdle_ram #(.WIDTH(RDW), .DEPTH(READY_SLOTS)) u_ready (
      .clock(clock), .wr_en(r_we), .wr_addr(r_wa), .wr_data(r_wd),
      .rd_addr(r_ra), .rd_data(r_rd));

   logic [47:0] due1, due2;
   assign due1 = clamp(base_ff);
   assign due2 = clamp(base_ff + 51'(extra_ff));
   logic [27:0] hl;
   assign hl = {req_ff.packet_handle, req_ff.packet_len};

   // update scan: address issued at scan_ff, data seen in the next cycle
   logic [SW-1:0] scan_idx_ff;
   logic upd_hit, upd_end;
   assign upd_hit = scan_pend_ff && sv_ff[scan_idx_ff] && (rcnt_ff != READY_MAX)
                    && (s_rd[47:0] <= time_ff);
   assign upd_end = (scan_ff == (SW+1)'(SLOTS)) && !scan_pend_ff;

   // receive scan
   logic [RW-1:0] ridx_ff;
   logic rcv_hit, rcv_end, rcv_stop;
   assign rcv_hit = rpend_ff && rv_ff[ridx_ff] && (r_rd[59:28] == req_ff.dst_addr);
   assign rcv_stop = (nout_ff == maxc_ff);
   assign rcv_end = !rpend_ff && !rcv_hit && (rcv_stop || rscan_ff >= rcnt_ff);

   logic send2_ff;
   logic [DW-1:0] s_wd2;
   assign s_wd2 = {req_ff.src_addr, req_ff.dst_addr, hl, due2};

   always_comb begin
      s_we = 1'b0; s_wa = wp_ff; s_wd = {req_ff.src_addr, req_ff.dst_addr, hl, due1};
      s_ra = scan_ff[SW-1:0];
      r_we = upd_hit; r_wa = rcnt_ff[RW-1:0]; r_wd = s_rd[DW-1:48];
      r_ra = rscan_ff[RW-1:0];
      if (st_cmd[3] && !drop) s_we = 1'b1;
      // second copy goes in the cycle after the first
      if (send2_ff) begin
         s_we = 1'b1;
         s_wd = s_wd2;
      end
   end

   // a found entry waits here until the next hit or the end of the scan
   logic held_ff;
   pdle_pkg::rsp_type hold_ff, found_rsp, fin_rsp;
   assign found_rsp = {1'b1, r_rd[RDW-1:60], r_rd[27:12], r_rd[11:0], 1'b0};
   always_comb begin
      fin_rsp = held_ff ? hold_ff : '0;
      fin_rsp.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff <= '0; rv_ff <= '0; rcnt_ff <= '0; wp_ff <= '0; time_ff <= '0;
         scan_ff <= '0; scan_pend_ff <= 1'b0; rpend_ff <= 1'b0; rscan_ff <= '0;
         nout_ff <= '0; send2_ff <= 1'b0; held_ff <= 1'b0;
      end else begin
         send2_ff <= st_cmd[3] && !drop && dup;
         if (st_cmd[3] && !drop) begin
            sv_ff[wp_ff] <= 1'b1;
            wp_ff <= (wp_ff == SLOT_LAST) ? '0 : wp_ff + 1'b1;
         end
         if (send2_ff) begin
            sv_ff[wp_ff] <= 1'b1;
            wp_ff <= (wp_ff == SLOT_LAST) ? '0 : wp_ff + 1'b1;
         end
         if (st_cmd[5]) begin
            time_ff <= req.time_now; rv_ff <= '0; rcnt_ff <= '0;
            scan_ff <= '0; scan_pend_ff <= 1'b0;
         end
         if (st_cmd[2]) begin
            scan_pend_ff <= (scan_ff != (SW+1)'(SLOTS));
            scan_idx_ff  <= scan_ff[SW-1:0];
            if (scan_ff != (SW+1)'(SLOTS)) scan_ff <= scan_ff + 1'b1;
            if (upd_hit) begin
               rv_ff[rcnt_ff[RW-1:0]] <= 1'b1;
               rcnt_ff <= rcnt_ff + 1'b1;
               sv_ff[scan_idx_ff] <= 1'b0;
            end
         end
         if (st_cmd[4]) begin
            rscan_ff <= '0; rpend_ff <= 1'b0; nout_ff <= '0; held_ff <= 1'b0;
         end
         if (st_cmd[1]) begin
            rpend_ff <= !rpend_ff && !rcv_end;
            if (rcv_hit) begin
               rv_ff[ridx_ff] <= 1'b0;
               nout_ff <= nout_ff + 1'b1;
               held_ff <= 1'b1;
            end else if (rcv_end) begin
               held_ff <= 1'b0;
            end else if (!rpend_ff) begin
               ridx_ff <= rscan_ff[RW-1:0];
               rscan_ff <= rscan_ff + 1'b1;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (st_cmd[6] || st_cmd[5] || st_cmd[4]) begin
         req_ff <= req;
         maxc_ff <= (req.max_count > 7'd64) ? 7'd64 : req.max_count;
         base_ff <= $signed({3'b0, time_ff}) + $signed(51'(latency_ff))
                    + ((jitter_ff != '0) ? ($signed(51'(span)) - $signed(51'(jitter_ff))) : 51'sd0);
         extra_ff <= extra;
      end
      if (st_cmd[1] && rcv_hit) begin
         hold_ff <= found_rsp;
         if (held_ff) rsp <= hold_ff;
      end else if (st_cmd[1] && rcv_end) begin
         rsp <= fin_rsp;
      end
   end

   // a held result goes out on the next hit, the final one at the end of the scan
   assign dp_status = {upd_end, dup, drop, rcv_end,
                       rcv_hit && held_ff, rsp.last, 1'b0};
endmodule
`default_nettype wire

@@ design/packet_delay_loss_emulator_top.sv @@
// top level of the packet delay/loss emulator
// depends on pdle_pkg, pdle_if, pdle_ctrl, pdle_dp
`default_nettype none
// Keeps packet descriptors in a ring and releases them after a delay. A send passes
// through one send step, and a second when it is duplicated; an update walks every
// slot of the ring through its single ram read port before the next request is taken; a
// receive walks the ready list, issuing each entry's address and then checking its data,
// and holds each found packet until the next hit or the end of the walk, so that the
// final one carries last. Results of a receive leave one per handshake.
module packet_delay_loss_emulator_top #(
   parameter int unsigned SLOTS       = pdle_pkg::SLOTS_DEFAULT,
   parameter int unsigned READY_SLOTS = pdle_pkg::READY_SLOTS_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   pdle_req_if.sink   req,
   pdle_rsp_if.source rsp,
   pdle_csr_if.sink   csr
);
   logic [6:0] st_cmd, dp_status;
   pdle_pkg::rsp_type rsp_d;
   assign csr.ready = 1'b1;
   pdle_ctrl #(.SLOTS(SLOTS), .READY_SLOTS(READY_SLOTS)) u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
      .req_command(req.payload.command), .rsp_ready(rsp.ready), .rsp_valid(rsp.valid),
      .st_cmd(st_cmd), .dp_status(dp_status));
   pdle_dp #(.SLOTS(SLOTS), .READY_SLOTS(READY_SLOTS)) u_dp (
      .clock(clock), .reset(reset), .req(req.payload), .csr_we(csr.valid),
      .csr(csr.payload), .st_cmd(st_cmd), .dp_status(dp_status), .rsp(rsp_d));
   assign rsp.payload = rsp_d;

   a_no_rsp_when_ready: assert property (@(posedge clock) disable iff (reset)
      !(rsp.valid && req.ready)) else $error("result pending while idle");
   a_found_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.payload.found) |-> rsp.payload.last)
      else $error("empty result not final");
endmodule
`default_nettype wire

@@ dv/tb_packet_delay_loss_emulator_top.sv @@
// testbench for packet_delay_loss_emulator_top: random and directed send/update/receive requests
// checked against an internal predictor; depends on pdle_pkg and pdle_if
`default_nettype none
module tb_packet_delay_loss_emulator_top;
   import pdle_pkg::*;

   localparam int unsigned NSLOT = 256;
   localparam int unsigned NREADY = 64;
   localparam logic [47:0] TIME_TOP = 48'hFFFF_FFFF_FFFF;

   class delivery_scoreboard;
      bit          ring_used [NSLOT];
      logic [31:0] ring_src [NSLOT];
      logic [31:0] ring_dst [NSLOT];
      logic [27:0] ring_hl [NSLOT];
      logic [47:0] ring_due [NSLOT];
      bit          list_used [NREADY];
      logic [31:0] list_src [NREADY];
      logic [31:0] list_dst [NREADY];
      logic [27:0] list_hl [NREADY];
      int unsigned list_count;
      int unsigned wr_ptr;
      logic [47:0] now_us;
      logic [19:0] latency, jitter;
      logic [16:0] loss_thr, dup_thr;
      rsp_type     pending_rsp[$];
      int unsigned mismatches;
      int unsigned received;

      function void clear();
         foreach (ring_used[i]) ring_used[i] = 0;
         foreach (list_used[i]) list_used[i] = 0;
         list_count = 0;
         wr_ptr = 0;
         now_us = 0;
         latency = 0;
         jitter = 0;
         loss_thr = 0;
         dup_thr = 0;
         mismatches = 0;
         received = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [31:0] val);
         case (idx)
            CSR_LATENCY: latency = val[19:0];
            CSR_JITTER:  jitter = val[19:0];
            CSR_LOSS:    loss_thr = val[16:0];
            default:     dup_thr = val[16:0];
         endcase
      endfunction

      function logic [47:0] saturate(longint t);
         if (t < 0) return 48'd0;
         if (t > longint'(TIME_TOP)) return TIME_TOP;
         return t[47:0];
      endfunction

      function void store(req_type r, logic [47:0] due);
         ring_used[wr_ptr] = 1;
         ring_src[wr_ptr] = r.src_addr;
         ring_dst[wr_ptr] = r.dst_addr;
         ring_hl[wr_ptr] = {r.packet_handle, r.packet_len};
         ring_due[wr_ptr] = due;
         wr_ptr = (wr_ptr + 1) % NSLOT;
      endfunction

      function void note_request(req_type r);
         longint base, extra;
         int unsigned n, lim;
         rsp_type o;
         case (r.command)
            CMD_SEND: begin
               if (r.rand_loss >= loss_thr) begin
                  base = longint'(now_us) + longint'(latency);
                  if (jitter != 0)
                     base += longint'((64'(r.rand_jitter) * (2 * 64'(jitter))) / 64'd65535)
                             - longint'(jitter);
                  store(r, saturate(base));
                  if (r.rand_dup < dup_thr) begin
                     extra = longint'((64'(r.rand_dup_delay) * 64'd1000000) / 64'd65535);
                     store(r, saturate(base + extra));
                  end
               end
            end
            CMD_UPDATE: begin
               now_us = r.time_now;
               foreach (list_used[i]) list_used[i] = 0;
               list_count = 0;
               for (int i = 0; i < NSLOT; i++) begin
                  if (!ring_used[i]) continue;
                  if (list_count >= NREADY) break;
                  if (ring_due[i] <= r.time_now) begin
                     list_used[list_count] = 1;
                     list_src[list_count] = ring_src[i];
                     list_dst[list_count] = ring_dst[i];
                     list_hl[list_count] = ring_hl[i];
                     list_count++;
                     ring_used[i] = 0;
                  end
               end
            end
            CMD_RECEIVE: begin
               n = 0;
               lim = (r.max_count > 64) ? 64 : r.max_count;
               for (int i = 0; i < list_count; i++) begin
                  if (n == lim) break;
                  if (!list_used[i] || list_dst[i] != r.dst_addr) continue;
                  o.found = 1;
                  o.out_src_addr = list_src[i];
                  o.out_handle = list_hl[i][27:12];
                  o.out_len = list_hl[i][11:0];
                  o.last = 0;
                  list_used[i] = 0;
                  pending_rsp.push_back(o);
                  n++;
               end
               if (n == 0) begin
                  o = '0;
                  o.last = 1;
                  pending_rsp.push_back(o);
               end else begin
                  pending_rsp[$].last = 1;
               end
            end
            default: ;
         endcase
      endfunction

      function void check_result(rsp_type got);
         rsp_type exp;
         received++;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
            return;
         end
         exp = pending_rsp.pop_front();
         if (got.found !== exp.found || got.out_src_addr !== exp.out_src_addr ||
             got.out_handle !== exp.out_handle || got.out_len !== exp.out_len ||
             got.last !== exp.last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result mismatch: expected f=%0d src=%h h=%h len=%0d last=%0d, got f=%0d src=%h h=%h len=%0d last=%0d",
                        exp.found, exp.out_src_addr, exp.out_handle, exp.out_len, exp.last,
                        got.found, got.out_src_addr, got.out_handle, got.out_len, got.last);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   pdle_req_if req_ch ();
   pdle_rsp_if rsp_ch ();
   pdle_csr_if csr_ch ();

   packet_delay_loss_emulator_top dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source),
      .csr   (csr_ch.sink)
   );

   delivery_scoreboard sb = new();
   bit hold_off = 0;
   bit sender_done = 0;
   logic [31:0] dest_pool [4] = '{32'h0, 32'hFFFF_FFFF, 32'h1234_5678, 32'hA5A5_5A5A};

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   initial begin
      req_ch.valid = 0;
      req_ch.payload = '0;
      csr_ch.valid = 0;
      csr_ch.payload = '0;
      rsp_ch.ready = 0;
      sb.clear();
   end

   // sample at the rising edge
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) sb.note_request(req_ch.payload);
      if (!reset && rsp_ch.valid && rsp_ch.ready) sb.check_result(rsp_ch.payload);
   end

   // receiver stalls on its own pattern, plus a long hold-off when asked
   initial begin
      int unsigned phase;
      phase = 0;
      forever begin
         @(negedge clock);
         phase++;
         if (hold_off) rsp_ch.ready <= 0;
         else if (phase % 512 < 128) rsp_ch.ready <= 1;
         else rsp_ch.ready <= ($urandom_range(0, 3) != 0);
      end
   end

   task automatic write_reg(logic [1:0] idx, logic [31:0] val);
      csr_ch.payload <= '{index: idx, data: val};
      csr_ch.valid <= 1;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid <= 0;
      sb.set_reg(idx, val);
   endtask

   task automatic wait_idle();
      int unsigned guard;
      guard = 0;
      while (sb.pending_rsp.size() != 0 && guard < 200000) begin
         @(negedge clock);
         guard++;
      end
      repeat (300) @(negedge clock);
   endtask

   // sender burst gaps: valid stays high across back-to-back requests
   int unsigned burst_left = 0;

   task automatic push_request(req_type r);
      if (burst_left == 0) begin
         req_ch.valid <= 0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 8);
      end
      burst_left--;
      req_ch.payload <= r;
      req_ch.valid <= 1;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   function automatic req_type blank_request(logic [1:0] cmd);
      req_type r;
      r = '0;
      r.command = cmd;
      r.packet_len = 1;
      r.rand_loss = 16'hFFFF;
      r.rand_dup = 16'hFFFF;
      return r;
   endfunction

   function automatic req_type random_send();
      req_type r;
      r = blank_request(CMD_SEND);
      r.src_addr = $urandom;
      r.dst_addr = dest_pool[$urandom_range(0, 3)];
      r.packet_handle = $urandom;
      r.packet_len = $urandom;
      r.rand_loss = $urandom;
      r.rand_jitter = $urandom;
      r.rand_dup = $urandom;
      r.rand_dup_delay = $urandom;
      r.time_now = {$urandom, $urandom};
      r.max_count = $urandom;
      return r;
   endfunction

   function automatic req_type random_update();
      req_type r;
      r = random_send();
      r.command = CMD_UPDATE;
      if ($urandom_range(0, 9) == 0) r.time_now = {$urandom, $urandom};
      else r.time_now = sb.now_us + 48'($urandom_range(0, 1500000));
      return r;
   endfunction

   function automatic req_type random_receive();
      req_type r;
      r = random_send();
      r.command = CMD_RECEIVE;
      r.max_count = ($urandom_range(0, 4) == 0) ? 7'($urandom) : 7'($urandom_range(0, 64));
      return r;
   endfunction

   initial begin
      req_type r;
      int unsigned pick;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      repeat (2) @(negedge clock);

      // directed: reset thresholds never drop or duplicate
      r = blank_request(CMD_SEND);
      r.rand_loss = 0; r.rand_dup = 0; r.dst_addr = dest_pool[1];
      r.src_addr = 32'hFFFF_FFFF; r.packet_handle = 16'hFFFF; r.packet_len = 12'hFFF;
      push_request(r);
      r.packet_len = 0; r.packet_handle = 0; r.src_addr = 0;
      push_request(r);
      r = blank_request(CMD_RECEIVE); r.dst_addr = dest_pool[1]; r.max_count = 64;
      push_request(r);   // nothing ready yet
      r = blank_request(CMD_UPDATE);
      push_request(r);
      r = blank_request(CMD_RECEIVE); r.dst_addr = dest_pool[1]; r.max_count = 0;
      push_request(r);
      r.max_count = 7'h7F;
      push_request(r);
      r = blank_request(2'd3);
      push_request(r);   // unknown command
      req_ch.valid <= 0;
      wait_idle();

      // extremes: always drop, then always duplicate with large jitter
      write_reg(CSR_LOSS, 32'd65537);
      write_reg(CSR_LATENCY, 32'd1000000);
      write_reg(CSR_JITTER, 32'd1000000);
      write_reg(CSR_DUP, 32'd131071);
      r = blank_request(CMD_SEND); r.rand_loss = 16'hFFFF; r.dst_addr = dest_pool[2];
      push_request(r);   // dropped
      req_ch.valid <= 0;
      wait_idle();
      write_reg(CSR_LOSS, 32'd0);
      r.rand_jitter = 0; r.rand_dup = 16'hFFFF; r.rand_dup_delay = 16'hFFFF;
      push_request(r);   // jitter floor, duplicated one second later
      r.rand_jitter = 16'hFFFF; r.rand_dup_delay = 0;
      push_request(r);
      r = blank_request(CMD_UPDATE); r.time_now = TIME_TOP;
      push_request(r);
      r = blank_request(CMD_SEND); r.rand_jitter = 16'hFFFF; r.dst_addr = dest_pool[2];
      push_request(r);   // due saturates at the top of time
      r = blank_request(CMD_UPDATE); r.time_now = TIME_TOP;
      push_request(r);
      r = blank_request(CMD_RECEIVE); r.dst_addr = dest_pool[2]; r.max_count = 64;
      push_request(r);
      req_ch.valid <= 0;
      wait_idle();

      write_reg(CSR_LATENCY, 32'd0);
      write_reg(CSR_JITTER, 32'd200);
      write_reg(CSR_DUP, 32'd0);
      r = blank_request(CMD_UPDATE); r.time_now = 0;
      push_request(r);
      r = blank_request(CMD_SEND); r.rand_jitter = 0; r.dst_addr = dest_pool[0];
      push_request(r);   // negative due clamps to zero
      r = blank_request(CMD_UPDATE); r.time_now = 0;
      push_request(r);
      r = blank_request(CMD_RECEIVE); r.dst_addr = dest_pool[0]; r.max_count = 1;
      push_request(r);

      // random phases with differing settings
      for (int ph = 0; ph < 4; ph++) begin
         req_ch.valid <= 0;
         wait_idle();
         write_reg(CSR_LATENCY, $urandom_range(0, 3000));
         write_reg(CSR_JITTER, (ph == 3) ? 0 : $urandom_range(0, 2000));
         write_reg(CSR_LOSS, (ph == 0) ? 0 : $urandom_range(0, 20000));
         write_reg(CSR_DUP, (ph == 3) ? 65536 : $urandom_range(0, 20000));
         burst_left = 0;
         for (int k = 0; k < 90; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) r = random_send();
            else if (pick < 70) r = random_update();
            else if (pick < 98) r = random_receive();
            else r = blank_request(2'd3);
            if (ph == 2 && k == 30) hold_off = 1;
            push_request(r);
         end
      end
      req_ch.valid <= 0;
      sender_done = 1;
   end

   // long receiver hold-off counted in its own process
   initial begin
      forever begin
         @(negedge clock);
         if (hold_off) begin
            repeat (3000) @(negedge clock);
            hold_off = 0;
         end
      end
   end

   initial begin
      wait (sender_done);
      while (sb.pending_rsp.size() != 0) @(negedge clock);
      repeat (400) @(negedge clock);
      if (sb.mismatches == 0 && sb.pending_rsp.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #(8 * 3000000);
      $display("FAILURE");
      $finish;
   end
endmodule
`default_nettype wire
